>>> rtl/mam_pkg.sv
// ----------------------------------------------------------------------------
// mam_pkg
// shared types, codes and the microcode rom of the accumulator machine
// ----------------------------------------------------------------------------
`default_nettype none

package mam_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_READ = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  // micro-operations
  typedef enum logic [4:0] {
    OP_NONE     = 5'd0,
    OP_SAR_PC   = 5'd1,
    OP_MEM_RD   = 5'd2,
    OP_TMP_ACC  = 5'd3,
    OP_ACCL_PC1 = 5'd4,
    OP_PC_ACCL  = 5'd5,
    OP_ACC_TMP  = 5'd6,
    OP_DISPATCH = 5'd7,
    OP_TMP_SDR  = 5'd8,
    OP_SAR_TMPL = 5'd9,
    OP_ADD      = 5'd10,
    OP_FETCH    = 5'd11,
    OP_SUB      = 5'd12,
    OP_SDR_ACC  = 5'd13,
    OP_MEM_WR   = 5'd14,
    OP_PC_SDRL  = 5'd15,
    OP_HALT_Z   = 5'd16
  } op_t;

  localparam int unsigned InstrStride  = 10;
  localparam int unsigned InstrSlots   = 25;
  localparam logic [1:0]  StepsHalf    = 2'd2;
  localparam logic [1:0]  StepsWhole   = 2'd3;

  typedef struct packed {
    logic [15:0] high;
    logic [7:0]  low;
  } word_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  mem_index;
    word_t       load;
  } item_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    word_t       data;
  } mem_wr_t;

  typedef struct packed {
    logic        halted;
    logic        fault;
    logic [15:0] acc_high;
    logic [7:0]  acc_low;
    logic [7:0]  micro_addr;
    logic [31:0] micro_steps;
    logic [31:0] machine_steps;
  } status_t;

  // control store, unmapped addresses give OP_NONE
  function automatic op_t rom_op(input logic [7:0] addr);
    op_t op;
    unique case (addr)
      8'd0:                                      op = OP_SAR_PC;
      8'd1, 8'd12, 8'd22, 8'd32:                 op = OP_MEM_RD;
      8'd2:                                      op = OP_TMP_ACC;
      8'd3:                                      op = OP_ACCL_PC1;
      8'd4:                                      op = OP_PC_ACCL;
      8'd5, 8'd34:                               op = OP_ACC_TMP;
      8'd6:                                      op = OP_DISPATCH;
      8'd10, 8'd13, 8'd20, 8'd23, 8'd30, 8'd33, 8'd40:
                                                 op = OP_TMP_SDR;
      8'd11, 8'd21, 8'd31, 8'd41:                op = OP_SAR_TMPL;
      8'd14:                                     op = OP_ADD;
      8'd15, 8'd25, 8'd35, 8'd44, 8'd51, 8'd61, 8'd63:
                                                 op = OP_FETCH;
      8'd24:                                     op = OP_SUB;
      8'd42:                                     op = OP_SDR_ACC;
      8'd43:                                     op = OP_MEM_WR;
      8'd50, 8'd62:                              op = OP_PC_SDRL;
      8'd60:                                     op = OP_HALT_Z;
      default:                                   op = OP_NONE;
    endcase
    return op;
  endfunction

  // nonzero multiple of the instruction stride
  function automatic logic instr_boundary(input logic [7:0] addr);
    logic hit;
    hit = 1'b0;
    for (int k = 1; k <= InstrSlots; k++) begin
      if (addr == 8'(k * InstrStride)) hit = 1'b1;
    end
    return hit;
  endfunction

  // whole-register transfers count one extra step
  function automatic logic [1:0] op_steps(input op_t op);
    logic [1:0] s;
    unique case (op)
      OP_MEM_RD, OP_TMP_ACC, OP_ACC_TMP, OP_TMP_SDR,
      OP_ADD, OP_SUB, OP_SDR_ACC, OP_MEM_WR: s = StepsWhole;
      default:                               s = StepsHalf;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mam_ram.sv
// ----------------------------------------------------------------------------
// mam_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mam_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mam_core.sv
// ----------------------------------------------------------------------------
// mam_core
// architectural registers and one microinstruction of work per tick item
// ----------------------------------------------------------------------------
`default_nettype none

module mam_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire mam_pkg::item_t   item,
  input  wire mam_pkg::word_t   mem_word,
  output      mam_pkg::mem_wr_t wr,
  output      logic [7:0]       sar_nxt,
  output      mam_pkg::status_t status
);

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  uinstr_r, uinstr_nxt;
  logic [15:0] tmp_h_r, tmp_h_nxt, sdr_h_r, sdr_h_nxt, acc_h_r, acc_h_nxt;
  logic [7:0]  tmp_l_r, tmp_l_nxt, sdr_l_r, sdr_l_nxt, acc_l_r, acc_l_nxt;
  logic [7:0]  pc_r, pc_nxt, sar_r;
  logic        halt_r, halt_nxt, fault_r, fault_nxt;
  logic [31:0] utot_r, utot_nxt, mtot_r, mtot_nxt;
  mam_pkg::op_t op;
  logic        do_tick;

  assign do_tick = fire && (item.req == mam_pkg::REQ_TICK) && !halt_r;
  assign op      = mam_pkg::rom_op(ctrl_r);

  always_comb begin
    ctrl_nxt   = ctrl_r;
    uinstr_nxt = uinstr_r;
    tmp_h_nxt  = tmp_h_r;
    tmp_l_nxt  = tmp_l_r;
    sdr_h_nxt  = sdr_h_r;
    sdr_l_nxt  = sdr_l_r;
    acc_h_nxt  = acc_h_r;
    acc_l_nxt  = acc_l_r;
    pc_nxt     = pc_r;
    sar_nxt    = sar_r;
    halt_nxt   = halt_r;
    fault_nxt  = fault_r;
    utot_nxt   = utot_r;
    mtot_nxt   = mtot_r;
    wr         = '0;

    if (fire && (item.req == mam_pkg::REQ_LOAD)) begin
      wr.en   = 1'b1;
      wr.addr = item.mem_index;
      wr.data = item.load;
    end

    if (do_tick) begin
      if (mam_pkg::instr_boundary(uinstr_r)) mtot_nxt = mtot_r + 32'd1;
      uinstr_nxt = ctrl_r;
      utot_nxt   = utot_r + 32'(mam_pkg::op_steps(op));

      unique case (op)
        mam_pkg::OP_SAR_PC:   sar_nxt = pc_r;
        mam_pkg::OP_MEM_RD: begin
          sdr_h_nxt = mem_word.high;
          sdr_l_nxt = mem_word.low;
        end
        mam_pkg::OP_TMP_ACC: begin
          tmp_h_nxt = acc_h_r;
          tmp_l_nxt = acc_l_r;
        end
        mam_pkg::OP_ACCL_PC1: acc_l_nxt = pc_r + 8'd1;
        mam_pkg::OP_PC_ACCL:  pc_nxt = acc_l_r;
        mam_pkg::OP_ACC_TMP: begin
          acc_h_nxt = tmp_h_r;
          acc_l_nxt = tmp_l_r;
        end
        mam_pkg::OP_TMP_SDR: begin
          tmp_h_nxt = sdr_h_r;
          tmp_l_nxt = sdr_l_r;
        end
        mam_pkg::OP_SAR_TMPL: sar_nxt = tmp_l_r;
        mam_pkg::OP_ADD: begin
          acc_h_nxt = acc_h_r + tmp_h_r;
          acc_l_nxt = acc_l_r + tmp_l_r;
        end
        mam_pkg::OP_SUB: begin
          acc_h_nxt = acc_h_r - tmp_h_r;
          acc_l_nxt = acc_l_r - tmp_l_r;
        end
        mam_pkg::OP_SDR_ACC: begin
          sdr_h_nxt = acc_h_r;
          sdr_l_nxt = acc_l_r;
        end
        mam_pkg::OP_MEM_WR: begin
          wr.en   = 1'b1;
          wr.addr = sar_r;
          wr.data = {sdr_h_r, sdr_l_r};
        end
        mam_pkg::OP_PC_SDRL:  pc_nxt = sdr_l_r;
        mam_pkg::OP_HALT_Z: begin
          if (acc_h_r == 16'd0 && acc_l_r == 8'd0) halt_nxt = 1'b1;
        end
        default: ;
      endcase

      // sequencing: dispatch jumps to opcode times ten
      unique case (op)
        mam_pkg::OP_DISPATCH: ctrl_nxt = {sdr_h_r[4:0], 3'b000} + {sdr_h_r[6:0], 1'b0};
        mam_pkg::OP_FETCH:    ctrl_nxt = 8'd0;
        mam_pkg::OP_NONE: begin
          halt_nxt  = 1'b1;
          fault_nxt = 1'b1;
        end
        default:              ctrl_nxt = ctrl_r + 8'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      uinstr_r <= '0;
      tmp_h_r  <= '0;
      tmp_l_r  <= '0;
      sdr_h_r  <= '0;
      sdr_l_r  <= '0;
      acc_h_r  <= '0;
      acc_l_r  <= '0;
      pc_r     <= '0;
      sar_r    <= '0;
      halt_r   <= 1'b0;
      fault_r  <= 1'b0;
      utot_r   <= '0;
      mtot_r   <= '0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      uinstr_r <= uinstr_nxt;
      tmp_h_r  <= tmp_h_nxt;
      tmp_l_r  <= tmp_l_nxt;
      sdr_h_r  <= sdr_h_nxt;
      sdr_l_r  <= sdr_l_nxt;
      acc_h_r  <= acc_h_nxt;
      acc_l_r  <= acc_l_nxt;
      pc_r     <= pc_nxt;
      sar_r    <= sar_nxt;
      halt_r   <= halt_nxt;
      fault_r  <= fault_nxt;
      utot_r   <= utot_nxt;
      mtot_r   <= mtot_nxt;
    end
  end

  // status after the item in flight
  always_comb begin
    status.halted        = halt_nxt;
    status.fault         = fault_nxt;
    status.acc_high      = acc_h_nxt;
    status.acc_low       = acc_l_nxt;
    status.micro_addr    = ctrl_nxt;
    status.micro_steps   = utot_nxt;
    status.machine_steps = mtot_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/microcoded_accumulator_machine.sv
// ----------------------------------------------------------------------------
// microcoded_accumulator_machine
// microcoded teaching computer: memory load/read and one microinstruction
// tick per input word
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tdata: mem_index, load_high, load_low
//                                        tuser: req_type
//   out_     out  out_tvalid/out_tready  tdata: read, status and counters
//
// one word per clock sustained while the output is not stalled; out_tvalid
// rises once an accepted word has passed the input register, which is loaded
// together with the ram read, and then the result register
// the ram read data is registered, so the read address for a tick is the
// store address as left by the word ahead of it, taken straight from the core
// a write by the word ahead to the same entry is forwarded through a bypass
// synchronous active-low reset clears all but the payload registers, and the
// per-entry valid bits; an entry never written reads as zero, so no clearing
// pass is needed; a stalled output holds the input register and the ram read
// data, and in_tready drops only while both stages are full
// ----------------------------------------------------------------------------
`default_nettype none

module microcoded_accumulator_machine #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [31:0]  in_tdata,   // mem_index[7:0], load_high[23:8], load_low[31:24]
  input  wire logic [1:0]   in_tuser,   // req_type[1:0]
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [127:0] out_tdata   // read_high[15:0], read_low[23:16], is_halted[24],
                                        // is_fault[25], acc_high_out[41:26],
                                        // acc_low_out[49:42], micro_addr_out[57:50],
                                        // micro_steps[89:58], machine_steps[121:90]
);

  localparam int unsigned AW      = $clog2(MEM_DEPTH);
  localparam int unsigned WORD_W  = $bits(mam_pkg::word_t);
  localparam int unsigned OUT_PAD = 128 - 122;

  // entry number modulo the depth: four conditional subtracts, depth >= 16
  function automatic logic [AW-1:0] wrap_idx(input logic [7:0] v);
    logic [11:0] r;
    r = {4'b0000, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (12'(MEM_DEPTH) << k)) r = r - (12'(MEM_DEPTH) << k);
    end
    return r[AW-1:0];
  endfunction

  // input register stage
  logic              s1_valid_r;
  mam_pkg::item_t    s1_item_r;
  logic              s1_fire, in_fire;

  // result register
  logic              out_valid_r;
  logic [127:0]      out_data_r;

  // memory side
  mam_pkg::mem_wr_t  wr;
  mam_pkg::status_t  status;
  logic [7:0]        sar_nxt, ra_raw;
  logic [AW-1:0]     ra, wa;
  logic [WORD_W-1:0] ram_q;
  logic [MEM_DEPTH-1:0] vld_r;
  logic              rd_vld_r, byp_hit_r;
  mam_pkg::word_t    byp_word_r, mem_word, rd_word;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // reads take the request's entry, ticks the store address to come
  assign ra_raw = (in_tuser == mam_pkg::REQ_READ) ? in_tdata[7:0] : sar_nxt;
  assign ra     = wrap_idx(ra_raw);
  assign wa     = wrap_idx(wr.addr);

  mam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wa),
    .wdata (wr.data),
    .re    (in_fire),
    .raddr (ra),
    .rdata (ram_q)
  );

  // forwarded write wins, then unwritten entries read as zero
  always_comb begin
    if (byp_hit_r) begin
      mem_word = byp_word_r;
    end else if (rd_vld_r) begin
      mem_word = ram_q;
    end else begin
      mem_word = '0;
    end
  end

  mam_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (s1_item_r),
    .mem_word (mem_word),
    .wr       (wr),
    .sar_nxt  (sar_nxt),
    .status   (status)
  );

  assign rd_word = (s1_item_r.req == mam_pkg::REQ_READ) ? mem_word : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      byp_hit_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr.en) begin
        vld_r[wa] <= 1'b1;
      end
      if (in_fire) begin
        byp_hit_r <= wr.en && (wa == ra);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r  <= {in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[31:24]};
      rd_vld_r   <= vld_r[ra];
      byp_word_r <= wr.data;
    end
    if (s1_fire) begin
      out_data_r <= {{OUT_PAD{1'b0}}, status.machine_steps, status.micro_steps,
                     status.micro_addr, status.acc_low, status.acc_high,
                     status.fault, status.halted, rd_word.low, rd_word.high};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/mam_checker.sv
// ----------------------------------------------------------------------------
// mam_checker
// port-level checks on the accumulator machine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mam_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a fault always comes with a halt
  a_fault_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[25] || out_tdata[24]))
    else $error("fault without halt");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

endmodule

bind microcoded_accumulator_machine mam_checker u_mam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
